/* rtl/itu_pkg.sv */
// Shared types, constants and lookup functions for the timestamp converter.
package itu_pkg;

  // Fixed field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned YearW   = 14;
  localparam int unsigned FieldW  = 7;
  localparam int unsigned MilliW  = 10;
  localparam int unsigned FracW   = 2;
  localparam int unsigned MsW     = 49;
  localparam int unsigned OutDataW = ((MsW + 7) / 8) * 8;

  // Arithmetic constants
  localparam int unsigned Recip100   = 5243;   // floor(x / 100) = (x * 5243) >> 19
  localparam int unsigned RecipShift = 19;
  localparam int unsigned DayBias    = 719468; // days from 0000-03-01 to 1970-01-01
  localparam int unsigned SecPerDay  = 86400;
  localparam int unsigned SecPerHour = 3600;
  localparam int unsigned SecPerMin  = 60;
  localparam int unsigned MsPerSec   = 1000;

  // Cycles from capture until the last conversion stage holds its value
  localparam int unsigned ConvLat = 4;
  localparam int unsigned CntW    = $clog2(ConvLat + 1);

  // Snapshot of a parsed timestamp
  typedef struct packed {
    logic              syn_ok;
    logic [YearW-1:0]  year;
    logic [FieldW-1:0] month;
    logic [FieldW-1:0] day;
    logic [FieldW-1:0] hour;
    logic [FieldW-1:0] minute;
    logic [FieldW-1:0] second;
    logic [MilliW-1:0] milli;
    logic [FracW-1:0]  frac_cnt;
    logic              off_neg;
    logic [FieldW-1:0] off_hour;
    logic [FieldW-1:0] off_minute;
  } fields_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;
    logic capture;
    logic load_out;
  } ctrl_cmd_t;

  // Day of a March-based year on which a month starts
  function automatic logic [8:0] month_start(input logic [FieldW-1:0] m);
    logic [8:0] r;
    begin
      case (m)
        7'd3:    r = 9'd0;
        7'd4:    r = 9'd31;
        7'd5:    r = 9'd61;
        7'd6:    r = 9'd92;
        7'd7:    r = 9'd122;
        7'd8:    r = 9'd153;
        7'd9:    r = 9'd184;
        7'd10:   r = 9'd214;
        7'd11:   r = 9'd245;
        7'd12:   r = 9'd275;
        7'd1:    r = 9'd306;
        7'd2:    r = 9'd337;
        default: r = 9'd0;
      endcase
      return r;
    end
  endfunction

  // Length of a month; zero for a month outside the calendar
  function automatic logic [4:0] month_len(input logic [FieldW-1:0] m, input logic leap);
    logic [4:0] r;
    begin
      case (m)
        7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: r = 5'd31;
        7'd4, 7'd6, 7'd9, 7'd11:                    r = 5'd30;
        7'd2:    r = leap ? 5'd29 : 5'd28;
        default: r = 5'd0;
      endcase
      return r;
    end
  endfunction

endpackage

/* rtl/itu_parse.sv */
// Byte-wise grammar checker that collects the timestamp fields.
module itu_parse import itu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [ByteW-1:0] char_i,
  input  logic             last_i,
  output fields_t          snap_o
);

  typedef enum logic [4:0] {
    PH_YEAR, PH_DASH1, PH_MONTH, PH_DASH2, PH_DAY, PH_TEE, PH_HOUR, PH_COLON1,
    PH_MINUTE, PH_COLON2, PH_SECOND, PH_AFTER_SEC, PH_FRAC_FIRST, PH_FRAC_MORE,
    PH_OFF_HOUR, PH_OFF_COLON, PH_OFF_MINUTE, PH_DONE
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [2:0]        di_q, di_d;
  logic              failed_q, failed_d;
  logic [YearW-1:0]  year_q, year_d;
  logic [FieldW-1:0] month_q, month_d, day_q, day_d, hour_q, hour_d;
  logic [FieldW-1:0] minute_q, minute_d, second_q, second_d;
  logic [FieldW-1:0] ohour_q, ohour_d, omin_q, omin_d;
  logic [MilliW-1:0] milli_q, milli_d;
  logic [FracW-1:0]  fc_q, fc_d;
  logic              neg_q, neg_d;

  logic       is_dig;
  logic [3:0] dig;
  logic [2:0] di_inc;
  logic       full;
  logic       term_ok;

  assign is_dig = (char_i >= 8'h30) && (char_i <= 8'h39);
  assign dig    = char_i[3:0];
  assign di_inc = di_q + 3'd1;
  assign full   = (phase_q == PH_YEAR) ? (di_inc == 3'd4) : (di_inc == 3'd2);

  // Work out the next grammar position and field values for one byte
  always_comb begin
    phase_d  = phase_q;
    di_d     = di_q;
    failed_d = failed_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    ohour_d  = ohour_q;
    omin_d   = omin_q;
    milli_d  = milli_q;
    fc_d     = fc_q;
    neg_d    = neg_q;
    term_ok  = 1'b0;
    if (!failed_q) begin
      case (phase_q)
        PH_YEAR, PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE, PH_SECOND,
        PH_OFF_HOUR, PH_OFF_MINUTE: begin
          if (!is_dig) begin
            failed_d = 1'b1;
          end else begin
            case (phase_q)
              PH_YEAR:     year_d   = 14'(year_q * 14'd10 + 14'(dig));
              PH_MONTH:    month_d  = 7'(month_q * 7'd10 + 7'(dig));
              PH_DAY:      day_d    = 7'(day_q * 7'd10 + 7'(dig));
              PH_HOUR:     hour_d   = 7'(hour_q * 7'd10 + 7'(dig));
              PH_MINUTE:   minute_d = 7'(minute_q * 7'd10 + 7'(dig));
              PH_SECOND:   second_d = 7'(second_q * 7'd10 + 7'(dig));
              PH_OFF_HOUR: ohour_d  = 7'(ohour_q * 7'd10 + 7'(dig));
              default:     omin_d   = 7'(omin_q * 7'd10 + 7'(dig));
            endcase
            if (full) begin
              di_d    = 3'd0;
              phase_d = phase_e'(5'(phase_q + 5'd1));
            end else begin
              di_d = di_inc;
            end
          end
        end
        PH_DASH1, PH_DASH2: begin
          if (char_i == 8'h2D) phase_d = phase_e'(5'(phase_q + 5'd1));
          else failed_d = 1'b1;
        end
        PH_COLON1, PH_COLON2, PH_OFF_COLON: begin
          if (char_i == 8'h3A) phase_d = phase_e'(5'(phase_q + 5'd1));
          else failed_d = 1'b1;
        end
        PH_TEE: begin
          if (char_i == 8'h54 || char_i == 8'h74) phase_d = PH_HOUR;
          else failed_d = 1'b1;
        end
        PH_FRAC_FIRST, PH_FRAC_MORE: begin
          if (is_dig) begin
            if (fc_q != 2'd3) begin
              milli_d = 10'(milli_q * 10'd10 + 10'(dig));
              fc_d    = fc_q + 2'd1;
            end
            phase_d = PH_FRAC_MORE;
          end else if (phase_q == PH_FRAC_FIRST) begin
            failed_d = 1'b1;
          end else begin
            term_ok = 1'b1;
          end
        end
        PH_AFTER_SEC: begin
          if (char_i == 8'h2E) phase_d = PH_FRAC_FIRST;
          else term_ok = 1'b1;
        end
        default: failed_d = 1'b1;
      endcase
      // Terminator: Z, z or the sign of an offset
      if (term_ok) begin
        if (char_i == 8'h5A || char_i == 8'h7A) begin
          phase_d = PH_DONE;
        end else if (char_i == 8'h2B || char_i == 8'h2D) begin
          neg_d   = (char_i == 8'h2D);
          di_d    = 3'd0;
          phase_d = PH_OFF_HOUR;
        end else begin
          failed_d = 1'b1;
        end
      end
    end
  end

  // Snapshot of the string including the current byte
  always_comb begin
    snap_o.syn_ok     = !failed_d && (phase_d == PH_DONE);
    snap_o.year       = year_d;
    snap_o.month      = month_d;
    snap_o.day        = day_d;
    snap_o.hour       = hour_d;
    snap_o.minute     = minute_d;
    snap_o.second     = second_d;
    snap_o.milli      = milli_d;
    snap_o.frac_cnt   = fc_d;
    snap_o.off_neg    = neg_d;
    snap_o.off_hour   = ohour_d;
    snap_o.off_minute = omin_d;
  end

  // Advance on each transfer; clear after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_YEAR;
      di_q     <= '0;
      failed_q <= 1'b0;
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
      ohour_q  <= '0;
      omin_q   <= '0;
      milli_q  <= '0;
      fc_q     <= '0;
      neg_q    <= 1'b0;
    end else if (take_i) begin
      if (last_i) begin
        phase_q  <= PH_YEAR;
        di_q     <= '0;
        failed_q <= 1'b0;
        year_q   <= '0;
        month_q  <= '0;
        day_q    <= '0;
        hour_q   <= '0;
        minute_q <= '0;
        second_q <= '0;
        ohour_q  <= '0;
        omin_q   <= '0;
        milli_q  <= '0;
        fc_q     <= '0;
        neg_q    <= 1'b0;
      end else begin
        phase_q  <= phase_d;
        di_q     <= di_d;
        failed_q <= failed_d;
        year_q   <= year_d;
        month_q  <= month_d;
        day_q    <= day_d;
        hour_q   <= hour_d;
        minute_q <= minute_d;
        second_q <= second_d;
        ohour_q  <= ohour_d;
        omin_q   <= omin_d;
        milli_q  <= milli_d;
        fc_q     <= fc_d;
        neg_q    <= neg_d;
      end
    end
  end

endmodule

/* rtl/itu_conv.sv */
// Staged civil-date to Unix-millisecond conversion and the result register.
module itu_conv import itu_pkg::*; (
  input  logic           clk_i,
  input  logic           capture_i,
  input  logic           load_i,
  input  fields_t        fields_i,
  output logic           ok_o,
  output logic [MsW-1:0] ms_o
);

  fields_t f_q;

  // Stage 1
  logic [YearW-1:0]  yy1_q, yy1_d;
  logic [26:0]       pa1_q, pa1_d, pb1_q, pb1_d;
  logic [YearW-1:0]  year1_q;
  logic [FieldW-1:0] month1_q, day1_q;
  logic [9:0]        doy1_q, doy1_d;
  logic [18:0]       tsec1_q, tsec1_d, toff1_q, toff1_d;
  logic              neg1_q;
  logic [MilliW-1:0] milli1_q, milli1_d;
  logic              ok1_q, ok1_d;
  // Stage 2
  logic [7:0]        q1_2_q;
  logic [23:0]       d365_2_q, d365_2_d;
  logic signed [19:0] sod2_q, sod2_d;
  logic [MilliW-1:0] milli2_q;
  logic              ok2_q, ok2_d;
  logic [7:0]        q2;
  logic [YearW-1:0]  rem100;
  logic              leap;
  // Stage 3
  logic signed [24:0] days3_q, days3_d;
  logic signed [19:0] sod3_q;
  logic [MilliW-1:0] milli3_q;
  logic              ok3_q;
  // Stage 4
  logic signed [41:0] secs4_q, secs4_d;
  logic [MilliW-1:0] milli4_q;
  logic              ok4_q;
  // Result
  logic signed [51:0] ms_full;

  // Stage 1: year shift, reciprocal products, time of day, range checks
  always_comb begin
    yy1_d   = f_q.year - YearW'(f_q.month <= 7'd2);
    pa1_d   = 27'(yy1_d) * 27'(Recip100);
    pb1_d   = 27'(f_q.year) * 27'(Recip100);
    doy1_d  = 10'(10'(month_start(f_q.month)) + 10'(f_q.day) - 10'd1);
    tsec1_d = 19'(19'(f_q.hour) * 19'(SecPerHour) + 19'(f_q.minute) * 19'(SecPerMin)
                  + 19'(f_q.second));
    toff1_d = 19'(19'(f_q.off_hour) * 19'(SecPerHour)
                  + 19'(f_q.off_minute) * 19'(SecPerMin));
    case (f_q.frac_cnt)
      2'd0:    milli1_d = '0;
      2'd1:    milli1_d = 10'(f_q.milli * 10'd100);
      2'd2:    milli1_d = 10'(f_q.milli * 10'd10);
      default: milli1_d = f_q.milli;
    endcase
    ok1_d = f_q.syn_ok && (f_q.year != '0) && (f_q.month >= 7'd1) && (f_q.month <= 7'd12)
            && (f_q.day >= 7'd1) && (f_q.hour <= 7'd23) && (f_q.minute <= 7'd59)
            && (f_q.second <= 7'd59) && (f_q.off_hour <= 7'd23)
            && (f_q.off_minute <= 7'd59);
  end

  // Stage 2: leap year, month length, day count before century terms, offset
  always_comb begin
    q2       = pb1_q[26:RecipShift];
    rem100   = YearW'(year1_q - YearW'(q2) * YearW'(100));
    leap     = (year1_q[1:0] == 2'b00) && ((rem100 != '0) || (q2[1:0] == 2'b00));
    ok2_d    = ok1_q && (day1_q <= {2'b00, month_len(month1_q, leap)});
    d365_2_d = 24'(24'(yy1_q) * 24'd365 + 24'(yy1_q >> 2) + 24'(doy1_q));
    if (neg1_q) sod2_d = $signed({1'b0, tsec1_q}) + $signed({1'b0, toff1_q});
    else        sod2_d = $signed({1'b0, tsec1_q}) - $signed({1'b0, toff1_q});
  end

  // Stage 3: century corrections and epoch bias
  assign days3_d = $signed({1'b0, d365_2_q}) - $signed({17'b0, q1_2_q})
                   + $signed({19'b0, q1_2_q[7:2]}) - $signed(25'(DayBias));

  // Stage 4: seconds since the epoch
  assign secs4_d = 42'(days3_q * $signed(42'(SecPerDay)))
                   + $signed({{22{sod3_q[19]}}, sod3_q});

  // Result: milliseconds, forced to zero for a rejected string
  assign ms_full = 52'($signed({{10{secs4_q[41]}}, secs4_q}) * $signed(52'(MsPerSec)))
                   + $signed({42'b0, milli4_q});

  // Hold the captured fields and advance the stages every cycle
  always_ff @(posedge clk_i) begin
    if (capture_i) f_q <= fields_i;
    yy1_q    <= yy1_d;
    pa1_q    <= pa1_d;
    pb1_q    <= pb1_d;
    year1_q  <= f_q.year;
    month1_q <= f_q.month;
    day1_q   <= f_q.day;
    doy1_q   <= doy1_d;
    tsec1_q  <= tsec1_d;
    toff1_q  <= toff1_d;
    neg1_q   <= f_q.off_neg;
    milli1_q <= milli1_d;
    ok1_q    <= ok1_d;
    q1_2_q   <= pa1_q[26:RecipShift];
    d365_2_q <= d365_2_d;
    sod2_q   <= sod2_d;
    milli2_q <= milli1_q;
    ok2_q    <= ok2_d;
    days3_q  <= days3_d;
    sod3_q   <= sod2_q;
    milli3_q <= milli2_q;
    ok3_q    <= ok2_q;
    secs4_q  <= secs4_d;
    milli4_q <= milli3_q;
    ok4_q    <= ok3_q;
    if (load_i) begin
      ok_o <= ok4_q;
      ms_o <= ok4_q ? ms_full[MsW-1:0] : '0;
    end
  end

endmodule

/* rtl/itu_ctrl.sv */
// Controller: input and output handshakes and conversion sequencing.
module itu_ctrl import itu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid_i,
  input  logic      s_tlast_i,
  output logic      s_tready_o,
  output logic      m_tvalid_o,
  input  logic      m_tready_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {S_PARSE, S_CONV, S_WAIT} state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic            slot_free;
  logic            conv_done;

  assign slot_free     = !m_tvalid_o || m_tready_i;
  assign conv_done     = (state_q == S_WAIT)
                         || ((state_q == S_CONV) && (cnt_q == CntW'(ConvLat)));
  assign s_tready_o    = (state_q == S_PARSE);
  assign cmd_o.take    = s_tvalid_i && s_tready_o;
  assign cmd_o.capture = cmd_o.take && s_tlast_i;
  assign cmd_o.load_out = conv_done && slot_free;

  // Sequence the conversion and hold the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_PARSE;
      cnt_q      <= '0;
      m_tvalid_o <= 1'b0;
    end else begin
      case (state_q)
        S_PARSE: begin
          cnt_q <= '0;
          if (cmd_o.capture) state_q <= S_CONV;
        end
        S_CONV: begin
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(ConvLat)) state_q <= slot_free ? S_PARSE : S_WAIT;
        end
        S_WAIT: begin
          if (slot_free) state_q <= S_PARSE;
        end
        default: state_q <= S_PARSE;
      endcase
      if (cmd_o.load_out)  m_tvalid_o <= 1'b1;
      else if (m_tready_i) m_tvalid_o <= 1'b0;
    end
  end

  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!m_tvalid_o || m_tready_i))
    else $error("result loaded over an untaken result");

  a_capture_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == S_CONV) && (cnt_q == '0))
    else $error("final byte did not start conversion");

  a_no_take_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_PARSE) |-> !cmd_o.take)
    else $error("byte taken during conversion");

  a_valid_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_o) |-> $past(cmd_o.load_out))
    else $error("output valid without a loaded result");

endmodule

/* rtl/iso_timestamp_to_unix_ms_core.sv */
// Top level: timestamp string to Unix milliseconds converter.
//
//  channel  | dir | tdata                         | tuser   | tlast
//  s_axis   | in  | [7:0] char_byte               | -       | is_last
//  m_axis   | out | [48:0] unix_ms, [55:49] zero  | [0] ok  | -
//
// Bytes of a string are taken one per cycle. After the final byte, tready
// stays low while the staged date conversion runs and until the output
// register is free; the result then sits in the output register, and input
// resumes while it waits.
// Reset returns the grammar to the start of a string and clears the output valid flag.
// A stalled output holds its result; the next result waits until it is taken.
module iso_timestamp_to_unix_ms_core import itu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [ByteW-1:0]    s_axis_tdata_i,  // [7:0] char_byte
  input  logic                s_axis_tlast_i,  // is_last
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,  // [48:0] unix_ms, rest zero
  output logic                m_axis_tuser_o   // [0] ok
);

  ctrl_cmd_t      cmd;
  fields_t        snap;
  logic [MsW-1:0] ms;

  itu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tlast_i  (s_axis_tlast_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .cmd_o      (cmd)
  );

  itu_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (cmd.take),
    .char_i (s_axis_tdata_i),
    .last_i (s_axis_tlast_i),
    .snap_o (snap)
  );

  itu_conv u_conv (
    .clk_i     (clk_i),
    .capture_i (cmd.capture),
    .load_i    (cmd.load_out),
    .fields_i  (snap),
    .ok_o      (m_axis_tuser_o),
    .ms_o      (ms)
  );

  assign m_axis_tdata_o = {{(OutDataW - MsW){1'b0}}, ms};

endmodule
